### rtl/core/stt_pkg.sv
`default_nettype none

package stt_pkg;

   localparam int OffsetBitsDefault = 16;
   localparam int LenBits           = 16;
   localparam int OutOffsetBits     = 16;
   localparam int KindBits          = 4;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_NUM   = 2'd1,
      MODE_IDENT = 2'd2,
      MODE_COLON = 2'd3
   } mode_type;

   typedef enum logic [KindBits-1:0] {
      KIND_PLUS    = 4'd0,
      KIND_MINUS   = 4'd1,
      KIND_STAR    = 4'd2,
      KIND_SLASH   = 4'd3,
      KIND_DCOLON  = 4'd4,
      KIND_COLON   = 4'd5,
      KIND_LPAREN  = 4'd6,
      KIND_RPAREN  = 4'd7,
      KIND_LBRACE  = 4'd8,
      KIND_RBRACE  = 4'd9,
      KIND_COMMA   = 4'd10,
      KIND_IDENT   = 4'd11,
      KIND_NUMBER  = 4'd12,
      KIND_END     = 4'd13
   } kind_type;

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_SPACE,
      CLS_COLON,
      CLS_SYMBOL,
      CLS_END
   } cls_type;

   typedef struct packed {
      kind_type                 kind;
      logic [OutOffsetBits-1:0] start;
      logic [LenBits-1:0]       len;
      logic                     last;
   } token_type;

   // up to two tokens produced by one byte, slot 0 first
   typedef struct packed {
      logic [1:0] count;
      token_type  tok1;
      token_type  tok0;
   } push_type;

   localparam logic [7:0] ChColon      = 8'h3A;
   localparam logic [7:0] ChUnderscore = 8'h5F;

   function automatic logic is_symbol(input logic [7:0] c);
      logic hit;
      begin
         unique case (c)
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C: hit = 1'b1;
            default: hit = 1'b0;
         endcase
         return hit;
      end
   endfunction

   function automatic kind_type symbol_kind(input logic [7:0] c);
      kind_type k;
      begin
         unique case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            default: k = KIND_COMMA;
         endcase
         return k;
      end
   endfunction

   function automatic cls_type char_class(input logic [7:0] c);
      cls_type cls;
      begin
         priority if (c >= 8'h30 && c <= 8'h39) begin
            cls = CLS_DIGIT;
         end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                      c == ChUnderscore) begin
            cls = CLS_ALPHA;
         end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            cls = CLS_SPACE;
         end else if (c == ChColon) begin
            cls = CLS_COLON;
         end else if (is_symbol(c)) begin
            cls = CLS_SYMBOL;
         end else begin
            cls = CLS_END;
         end
         return cls;
      end
   endfunction

endpackage

`default_nettype wire

### rtl/core/stt_scan.sv
`default_nettype none

module stt_scan #(
   parameter int OFFSET_BITS = stt_pkg::OffsetBitsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_char_byte,
   input  wire logic             room,
   output stt_pkg::push_type     push
);
   import stt_pkg::*;

   localparam int ExtW = (OFFSET_BITS > OutOffsetBits) ? OFFSET_BITS : OutOffsetBits;
   localparam logic [LenBits-1:0] LenMax = '1;

   logic                   in_vld_ff, in_vld_in;
   logic [7:0]             byte_ff;
   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LenBits-1:0]     len_ff, len_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   logic     fire;
   cls_type  cls;
   mode_type eff_mode;
   logic     word_char;
   logic [1:0] n;
   token_type  tok [2];

   function automatic logic [OutOffsetBits-1:0] out_off(input logic [OFFSET_BITS-1:0] v);
      logic [ExtW-1:0] ext;
      begin
         ext = ExtW'(v);
         return ext[OutOffsetBits-1:0];
      end
   endfunction

   assign fire      = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && !req_stall) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      cls       = char_class(byte_ff);
      word_char = (cls == CLS_DIGIT) || (cls == CLS_ALPHA);
      mode_in   = mode_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      pos_in    = pos_ff + OFFSET_BITS'(1);
      eff_mode  = mode_ff;
      n         = 2'd0;
      for (int i = 0; i < 2; i++) begin
         tok[i] = '{kind: KIND_PLUS, start: '0, len: '0, last: 1'b0};
      end

      if (mode_ff == MODE_COLON) begin
         if (byte_ff == ChColon) begin
            tok[0] = '{kind: KIND_DCOLON, start: out_off(start_ff),
                       len: LenBits'(2), last: 1'b0};
            n        = 2'd1;
            mode_in  = MODE_NONE;
            eff_mode = MODE_COLON;   // item fully handled
         end else begin
            tok[0] = '{kind: KIND_COLON, start: out_off(start_ff),
                       len: LenBits'(1), last: 1'b0};
            n        = 2'd1;
            eff_mode = MODE_NONE;
         end
      end

      if (eff_mode != MODE_COLON) begin
         if ((eff_mode == MODE_NUM && cls == CLS_DIGIT) ||
             (eff_mode == MODE_IDENT && word_char)) begin
            if (len_ff != LenMax) begin
               len_in = len_ff + LenBits'(1);
            end
         end else begin
            if (eff_mode == MODE_NUM || eff_mode == MODE_IDENT) begin
               tok[n[0]] = '{kind: (eff_mode == MODE_NUM) ? KIND_NUMBER : KIND_IDENT,
                             start: out_off(start_ff), len: len_ff, last: 1'b0};
               n = n + 2'd1;
            end
            mode_in = MODE_NONE;
            unique case (cls)
               CLS_DIGIT, CLS_ALPHA: begin
                  mode_in  = (cls == CLS_DIGIT) ? MODE_NUM : MODE_IDENT;
                  start_in = pos_ff;
                  len_in   = LenBits'(1);
               end
               CLS_SPACE: begin
               end
               CLS_COLON: begin
                  mode_in  = MODE_COLON;
                  start_in = pos_ff;
                  len_in   = LenBits'(1);
               end
               CLS_SYMBOL: begin
                  tok[n[0]] = '{kind: symbol_kind(byte_ff), start: out_off(pos_ff),
                                len: LenBits'(1), last: 1'b0};
                  n = n + 2'd1;
               end
               default: begin
                  // end of buffer: restart offsets at zero
                  tok[n[0]] = '{kind: KIND_END, start: out_off(pos_ff),
                                len: '0, last: 1'b0};
                  n        = n + 2'd1;
                  start_in = '0;
                  len_in   = '0;
                  pos_in   = '0;
               end
            endcase
         end
      end

      tok[0].last = (n == 2'd1);
      tok[1].last = 1'b1;
      push.count  = fire ? n : 2'd0;
      push.tok0   = tok[0];
      push.tok1   = tok[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         mode_ff   <= MODE_NONE;
         start_ff  <= '0;
         len_ff    <= '0;
         pos_ff    <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (fire) begin
            mode_ff  <= mode_in;
            start_ff <= start_in;
            len_ff   <= len_in;
            pos_ff   <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_char_byte;
      end
   end

endmodule

`default_nettype wire

### rtl/core/stt_token_fifo.sv
`default_nettype none

module stt_token_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stt_pkg::push_type  push,
   output logic                    room,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output stt_pkg::token_type      rsp_token
);
   import stt_pkg::*;

   token_type  mem [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   // room for a full two-token item regardless of this cycle's pop
   assign room      = (cnt_ff <= 3'd2);
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_token = mem[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_in  = wr_ff + push.count;
      rd_in  = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ff + 2'd1] <= push.tok1;
      end
   end

endmodule

`default_nettype wire

### rtl/core/source_text_tokenizer.sv
// Source text tokenizer.
// Input channel (req_): one source byte per item on req_char_byte, taken when
// req_valid is high and req_stall low. Result channel (rsp_): one token per
// item with kind, start offset, length and rsp_last marking the final token
// caused by a byte; a byte gives zero, one or two tokens.
// The byte is registered, classified and merged with the pending token in one
// pass; tokens land in a four-entry output queue and are registered there
// before rsp_; a byte waits in the input register while the queue lacks room.
// Throughput: one byte per cycle while the queue holds at most two tokens; a
// byte giving two tokens uses the output port twice, so the port (one token
// per cycle, rsp_stall low) sets the sustained rate on symbol-dense text.
// When the receiver stalls, the queue fills and req_stall rises once the
// registered byte finds fewer than two free entries; nothing is dropped.
// Reset (synchronous) empties the queue and input register, clears the
// pending token and restarts offsets at zero.
`default_nettype none

module source_text_tokenizer #(
   parameter int OFFSET_BITS = stt_pkg::OffsetBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_token_kind,
   output logic [15:0]      rsp_start_offset,
   output logic [15:0]      rsp_token_length,
   output logic             rsp_last
);
   import stt_pkg::*;

   push_type  push;
   logic      room;
   token_type rsp_token;

   stt_scan #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_char_byte(req_char_byte),
      .room         (room),
      .push         (push)
   );

   stt_token_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_token(rsp_token)
   );

   assign rsp_token_kind   = rsp_token.kind;
   assign rsp_start_offset = rsp_token.start;
   assign rsp_token_length = rsp_token.len;
   assign rsp_last         = rsp_token.last;

endmodule

`default_nettype wire
